/* src/homography_displacement_map_defines.svh */
// Assertion macros shared by the homography displacement map RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef HOMOGRAPHY_DISPLACEMENT_MAP_DEFINES_SVH
`define HOMOGRAPHY_DISPLACEMENT_MAP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HDM_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HDM_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* src/hdm_pkg.sv */
// Constants shared by the homography displacement map.
// No dependencies.
package hdm_pkg;

    // Register indexes on the configuration port.
    localparam int CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_XX = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHEAR_XY = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_X = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHEAR_YX = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCALE_YY = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_Y = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERSP_X  = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERSP_Y  = 4'd7;

    localparam int CFG_DATA_BITS = 48;
    localparam int AFF_BITS      = 32;
    localparam int PERSP_BITS    = 48;

    // 1.0 in Q8.24.
    localparam logic [AFF_BITS-1:0] ONE_Q24 = 32'h0100_0000;

    // Quotient bits kept: anything at or above 2^QUO_BITS saturates anyway.
    localparam int QUO_BITS = 35;

    localparam int DISP_BITS      = 32;
    localparam int OUT_DATA_BITS  = 2 * DISP_BITS;
    localparam int OUT_USER_BITS  = 2;

    typedef struct packed {
        logic                 clipped;
        logic                 zero_denominator;
        logic [DISP_BITS-1:0] disp_y;
        logic [DISP_BITS-1:0] disp_x;
    } result_t;

endpackage

/* src/homography_displacement_map.sv */
// Homography displacement map: streaming top level, fully pipelined.
// Depends on hdm_pkg and homography_displacement_map_defines.svh.
//
// Usage:
//   s_* channel carries one pixel coordinate per word; m_* carries one
//   displacement result per word. Each accepted input word yields exactly
//   one output word, in order.
//   cfg_* writes one of the eight homography registers; write it only while
//   the pipeline is empty. cfg_ready is always high; unknown indexes drop.
// Throughput: one pixel per clock while the skid buffer is empty. The block is a
//   41-stage pipeline, set by the long divider: one quotient bit per stage, 35 stages
//   per coordinate, the X and Y dividers running side by side.
// Stall: the output register is backed by a one-word skid buffer, so the
//   pipeline keeps accepting while one result waits. Once the skid holds a
//   word, s_tready drops and every stage holds until m_tready frees a slot.
// Reset: rst_n, asynchronous, active low, empties every stage and restores
//   the identity homography (scale terms 1.0, all others zero).
module homography_displacement_map #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // s_tdata: pix_x, pix_y (from bit 0 up), zero padded to bytes
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // m_tdata: disp_x, disp_y (from bit 0 up)
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [hdm_pkg::OUT_DATA_BITS-1:0]     m_tdata,
    // m_tuser: zero_denominator, clipped (from bit 0 up)
    output logic [hdm_pkg::OUT_USER_BITS-1:0]     m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hdm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [hdm_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import hdm_pkg::*;
    `include "homography_displacement_map_defines.svh"

    localparam int CB  = COORD_BITS;
    localparam int PA  = AFF_BITS + CB + 1;     // affine product
    localparam int NW  = PA + 2;                // X, Y sums
    localparam int PP  = PERSP_BITS + CB + 1;   // perspective product
    localparam int DW  = PP + 2;                // W sum and its magnitude
    localparam int QB  = QUO_BITS;
    localparam int PJ  = QB + 2;                // signed projection
    localparam int DF  = ((PJ > CB + 17) ? PJ : CB + 17) + 1;

    // ---------------- configuration registers ----------------
    logic signed [AFF_BITS-1:0]   sxx_reg, sxy_reg, ox_reg, syx_reg, syy_reg, oy_reg;
    logic signed [PERSP_BITS-1:0] px_reg, py_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sxx_reg <= ONE_Q24;
            sxy_reg <= '0;
            ox_reg  <= '0;
            syx_reg <= '0;
            syy_reg <= ONE_Q24;
            oy_reg  <= '0;
            px_reg  <= '0;
            py_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SCALE_XX: sxx_reg <= cfg_data[AFF_BITS-1:0];
                REG_SHEAR_XY: sxy_reg <= cfg_data[AFF_BITS-1:0];
                REG_OFFSET_X: ox_reg  <= cfg_data[AFF_BITS-1:0];
                REG_SHEAR_YX: syx_reg <= cfg_data[AFF_BITS-1:0];
                REG_SCALE_YY: syy_reg <= cfg_data[AFF_BITS-1:0];
                REG_OFFSET_Y: oy_reg  <= cfg_data[AFF_BITS-1:0];
                REG_PERSP_X:  px_reg  <= cfg_data[PERSP_BITS-1:0];
                REG_PERSP_Y:  py_reg  <= cfg_data[PERSP_BITS-1:0];
                default:      ;  // unknown index: drop the write
            endcase
        end
    end

    // ---------------- stage types ----------------
    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } coord_t;

    typedef struct packed {
        logic [CB-1:0]        x;
        logic [CB-1:0]        y;
        logic signed [PA-1:0] a_xx, a_xy, a_yx, a_yy;
        logic signed [PP-1:0] p_x, p_y;
    } prod_t;

    typedef struct packed {
        logic [CB-1:0]        x;
        logic [CB-1:0]        y;
        logic signed [NW-1:0] bx, by;
        logic signed [DW-1:0] w;
    } sum_t;

    // Divider word: remainders, denominator magnitude, low numerator bits.
    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic          zero;
        logic          neg_x, neg_y;
        logic          ov_x, ov_y;
        logic [DW-1:0] d;
        logic [DW-1:0] r_x, r_y;
        logic [2:0]    l_x, l_y;
        logic [QB-1:0] q_x, q_y;
    } div_t;

    // Whole pipeline moves together; the skid buffer absorbs one word.
    logic en;

    // ---------------- stage 1: input register ----------------
    coord_t s1_reg;
    logic   v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.x <= s_tdata[CB-1:0];
            s1_reg.y <= s_tdata[2*CB-1:CB];
        end
    end

    assign s_tready = en;

    // ---------------- stage 2: products ----------------
    prod_t s2_reg, s2_next;
    logic  v2_reg;

    always_comb
    begin
        s2_next.x    = s1_reg.x;
        s2_next.y    = s1_reg.y;
        s2_next.a_xx = sxx_reg * $signed({1'b0, s1_reg.x});
        s2_next.a_xy = sxy_reg * $signed({1'b0, s1_reg.y});
        s2_next.a_yx = syx_reg * $signed({1'b0, s1_reg.x});
        s2_next.a_yy = syy_reg * $signed({1'b0, s1_reg.y});
        s2_next.p_x  = px_reg * $signed({1'b0, s1_reg.x});
        s2_next.p_y  = py_reg * $signed({1'b0, s1_reg.y});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s2_reg <= s2_next;
    end

    // ---------------- stage 3: X, Y, W sums ----------------
    sum_t s3_reg, s3_next;
    logic v3_reg;

    always_comb
    begin
        s3_next.x  = s2_reg.x;
        s3_next.y  = s2_reg.y;
        // offsets are Q16.16: align to 24 fraction bits
        s3_next.bx = {{2{s2_reg.a_xx[PA-1]}}, s2_reg.a_xx}
                   + {{2{s2_reg.a_xy[PA-1]}}, s2_reg.a_xy}
                   + {{(NW-AFF_BITS-8){ox_reg[AFF_BITS-1]}}, ox_reg, 8'd0};
        s3_next.by = {{2{s2_reg.a_yx[PA-1]}}, s2_reg.a_yx}
                   + {{2{s2_reg.a_yy[PA-1]}}, s2_reg.a_yy}
                   + {{(NW-AFF_BITS-8){oy_reg[AFF_BITS-1]}}, oy_reg, 8'd0};
        // 1.0 in Q.40
        s3_next.w  = {{2{s2_reg.p_x[PP-1]}}, s2_reg.p_x}
                   + {{2{s2_reg.p_y[PP-1]}}, s2_reg.p_y}
                   + {{(DW-41){1'b0}}, 1'b1, 40'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s3_reg <= s3_next;
    end

    // ---------------- stage 4: sign and magnitude ----------------
    div_t s4_reg, s4_next;
    logic v4_reg;

    always_comb
    begin
        logic [NW-1:0] mx, my;
        mx = s3_reg.bx[NW-1] ? NW'(-s3_reg.bx) : NW'(s3_reg.bx);
        my = s3_reg.by[NW-1] ? NW'(-s3_reg.by) : NW'(s3_reg.by);
        s4_next       = '0;
        s4_next.x     = s3_reg.x;
        s4_next.y     = s3_reg.y;
        s4_next.zero  = (s3_reg.w == '0);
        s4_next.neg_x = s3_reg.bx[NW-1] ^ s3_reg.w[DW-1];
        s4_next.neg_y = s3_reg.by[NW-1] ^ s3_reg.w[DW-1];
        s4_next.d     = s3_reg.w[DW-1] ? DW'(-s3_reg.w) : DW'(s3_reg.w);
        // park the numerator magnitudes in the remainder fields
        s4_next.r_x   = {{(DW-NW){1'b0}}, mx};
        s4_next.r_y   = {{(DW-NW){1'b0}}, my};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s4_reg <= s4_next;
    end

    // ---------------- stage 5: overflow check, divider setup ----------------
    // Numerator is mag * 2^32; quotient bits QB-1..0 take mag[2:0] then zeros.
    // A quotient of 2^QB or more shows as (mag >> 3) >= d.
    div_t dv_reg  [QB+1];
    div_t dv_next [QB+1];
    logic [QB:0] vd_reg;

    always_comb
    begin
        logic [DW-1:0] hx, hy;
        hx          = s4_reg.r_x >> 3;
        hy          = s4_reg.r_y >> 3;
        dv_next[0]      = s4_reg;
        dv_next[0].ov_x = (hx >= s4_reg.d);
        dv_next[0].ov_y = (hy >= s4_reg.d);
        dv_next[0].r_x  = hx;
        dv_next[0].r_y  = hy;
        dv_next[0].l_x  = s4_reg.r_x[2:0];
        dv_next[0].l_y  = s4_reg.r_y[2:0];
        dv_next[0].q_x  = '0;
        dv_next[0].q_y  = '0;
    end

    // One restoring step: returns {quotient bit, new remainder}.
    function automatic logic [DW:0] div_step(input logic [DW-1:0] r, input logic b,
                                             input logic [DW-1:0] d);
        logic [DW:0] t;
        logic [DW:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
            return {1'b1, diff[DW-1:0]};
        else
            return {1'b0, t[DW-1:0]};
    endfunction

    // ---------------- stages 6..40: long division, one bit per stage ----------------
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [DW:0] sx, sy;
        logic        bx, by;

        assign bx = (k < 3) ? dv_reg[k].l_x[(k < 3) ? 2 - k : 0] : 1'b0;
        assign by = (k < 3) ? dv_reg[k].l_y[(k < 3) ? 2 - k : 0] : 1'b0;
        assign sx = div_step(dv_reg[k].r_x, bx, dv_reg[k].d);
        assign sy = div_step(dv_reg[k].r_y, by, dv_reg[k].d);

        always_comb
        begin
            dv_next[k+1]     = dv_reg[k];
            dv_next[k+1].r_x = sx[DW-1:0];
            dv_next[k+1].r_y = sy[DW-1:0];
            dv_next[k+1].q_x = {dv_reg[k].q_x[QB-2:0], sx[DW]};
            dv_next[k+1].q_y = {dv_reg[k].q_y[QB-2:0], sy[DW]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= '0;
        else if (en)
            vd_reg <= {vd_reg[QB-1:0], v4_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= QB; i++)
                dv_reg[i] <= dv_next[i];
        end
    end

    // ---------------- stage 41: projection minus position, saturate ----------------
    result_t fin_reg, fin_next;
    logic    vf_reg;

    function automatic logic [DISP_BITS:0] disp_calc(input logic [QB-1:0] q, input logic ov,
                                                     input logic neg, input logic zero,
                                                     input logic [CB-1:0] c);
        logic [QB:0]          mag;
        logic signed [PJ-1:0] proj;
        logic signed [DF-1:0] diff;
        logic [DF-32:0]       hi;
        mag  = ov ? {1'b1, {QB{1'b0}}} : {1'b0, q};
        proj = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (zero)
            proj = '0;
        diff = DF'(proj) - $signed({{(DF-CB-16){1'b0}}, c, 16'd0});
        hi   = diff[DF-1:31];
        if ((&hi) || !(|hi))
            return {1'b0, diff[DISP_BITS-1:0]};
        else
            return {1'b1, diff[DF-1] ? 32'h8000_0000 : 32'h7fff_ffff};
    endfunction

    always_comb
    begin
        logic [DISP_BITS:0] rx, ry;
        rx = disp_calc(dv_reg[QB].q_x, dv_reg[QB].ov_x, dv_reg[QB].neg_x,
                       dv_reg[QB].zero, dv_reg[QB].x);
        ry = disp_calc(dv_reg[QB].q_y, dv_reg[QB].ov_y, dv_reg[QB].neg_y,
                       dv_reg[QB].zero, dv_reg[QB].y);
        fin_next.disp_x           = rx[DISP_BITS-1:0];
        fin_next.disp_y           = ry[DISP_BITS-1:0];
        fin_next.zero_denominator = dv_reg[QB].zero;
        fin_next.clipped          = rx[DISP_BITS] | ry[DISP_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (en)
            vf_reg <= vd_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fin_reg <= fin_next;
    end

    // ---------------- output register and skid ----------------
    result_t out_reg, skid_reg;
    logic    out_v_reg, skid_v_reg;
    logic    arrive;

    assign en     = !skid_v_reg;
    assign arrive = en && vf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_v_reg && !m_tready)
        begin
            // output held: park a new word in the skid
            if (arrive)
                skid_v_reg <= 1'b1;
        end
        else if (skid_v_reg)
        begin
            out_v_reg  <= 1'b1;
            skid_v_reg <= 1'b0;
        end
        else
            out_v_reg <= arrive;
    end

    always_ff @(posedge clk)
    begin
        if (out_v_reg && !m_tready)
        begin
            if (arrive)
                skid_reg <= fin_reg;
        end
        else if (skid_v_reg)
            out_reg <= skid_reg;
        else if (arrive)
            out_reg <= fin_reg;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_reg.disp_y, out_reg.disp_x};
    assign m_tuser  = {out_reg.clipped, out_reg.zero_denominator};

    // ---------------- checks ----------------
    `HDM_ASSERT_IMP(a_skid_behind_out, skid_v_reg, out_v_reg,
                    "skid holds a word while output is empty")
    `HDM_ASSERT_IMP(a_skid_blocks_input, skid_v_reg, !s_tready,
                    "input accepted while skid is full")
    `HDM_ASSERT_NXT(a_skid_catches, out_v_reg && !m_tready && arrive, skid_v_reg,
                    "word arriving at a stalled output was not parked")

endmodule

/* sim/tb_top.sv */
// Testbench for homography_displacement_map: streams pixel words through the
// block and checks each displacement word against an in-bench predictor.
// Depends on hdm_pkg and the homography_displacement_map RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hdm_pkg::*;

    localparam int CB         = 12;
    localparam int LIMIT      = 600000;
    localparam int DRAIN_WAIT = 60;   // pipeline is 41 stages deep

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [23:0]               s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic [OUT_USER_BITS-1:0]  m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    homography_displacement_map #(.COORD_BITS(CB)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Shadow copy of the homography registers, masked to their widths.
    logic [47:0]   coef [8];
    // Pixel words waiting to go out, and displacements waiting to come back.
    logic [23:0]   pixel_q[$];
    result_t       disp_q[$];
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            fail_cnt = 0;
    int            pixels_sent = 0;
    int            disp_checked = 0;
    int            zero_den_seen = 0;
    int            clip_seen = 0;
    int            cycle_cnt = 0;

    // Projected coordinate in Q16.16: num has 24 fraction bits, den 40.
    // Truncate toward zero and limit the magnitude to 2^62.
    function automatic longint project_q16(longint num, longint den);
        bit [127:0] n;
        bit [127:0] d;
        bit [127:0] q;
        bit         neg;
        neg = (num < 0) ^ (den < 0);
        n = (num < 0) ? -num : num;
        n = n << 32;
        d = (den < 0) ? -den : den;
        q = n / d;
        if (q > (128'd1 << 62))
            q = 128'd1 << 62;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic result_t predict_disp(logic [23:0] word);
        result_t r;
        longint  x;
        longint  y;
        longint  bx;
        longint  by;
        longint  wd;
        longint  px;
        longint  py;
        longint  dv [2];
        bit      clip;
        x  = longint'({1'b0, word[CB-1:0]});
        y  = longint'({1'b0, word[2*CB-1:CB]});
        bx = longint'($signed(coef[REG_SCALE_XX][31:0])) * x
           + longint'($signed(coef[REG_SHEAR_XY][31:0])) * y
           + longint'($signed(coef[REG_OFFSET_X][31:0])) * 256;
        by = longint'($signed(coef[REG_SHEAR_YX][31:0])) * x
           + longint'($signed(coef[REG_SCALE_YY][31:0])) * y
           + longint'($signed(coef[REG_OFFSET_Y][31:0])) * 256;
        wd = longint'($signed(coef[REG_PERSP_X])) * x
           + longint'($signed(coef[REG_PERSP_Y])) * y + (64'sd1 <<< 40);
        r.zero_denominator = (wd == 0);
        // A zero denominator puts the projection at the origin.
        px = r.zero_denominator ? 0 : project_q16(bx, wd);
        py = r.zero_denominator ? 0 : project_q16(by, wd);
        dv[0] = px - x * 65536;
        dv[1] = py - y * 65536;
        clip = 1'b0;
        foreach (dv[i])
        begin
            if (dv[i] > 64'sd2147483647)
            begin
                dv[i] = 64'sd2147483647;
                clip  = 1'b1;
            end
            else if (dv[i] < -64'sd2147483648)
            begin
                dv[i] = -64'sd2147483648;
                clip  = 1'b1;
            end
        end
        r.disp_x  = dv[0][31:0];
        r.disp_y  = dv[1][31:0];
        r.clipped = clip;
        return r;
    endfunction

    // Driver: predict on acceptance, then advance to the next pixel word or idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                disp_q.insert(disp_q.size(), predict_disp(s_tdata));
                pixels_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted displacement word with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata};
                if (disp_q.size() == 0)
                begin
                    $error("unexpected displacement word %h", got);
                    fail_cnt++;
                end
                else
                begin
                    want = disp_q.pop_front();
                    disp_checked++;
                    zero_den_seen += got.zero_denominator;
                    clip_seen += got.clipped;
                    if (got.disp_x !== want.disp_x)
                    begin
                        $error("disp_x expected %h got %h", want.disp_x, got.disp_x);
                        fail_cnt++;
                    end
                    if (got.disp_y !== want.disp_y)
                    begin
                        $error("disp_y expected %h got %h", want.disp_y, got.disp_y);
                        fail_cnt++;
                    end
                    if (got.zero_denominator !== want.zero_denominator)
                    begin
                        $error("zero_denominator expected %b got %b",
                               want.zero_denominator, got.zero_denominator);
                        fail_cnt++;
                    end
                    if (got.clipped !== want.clipped)
                    begin
                        $error("clipped expected %b got %b", want.clipped, got.clipped);
                        fail_cnt++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Write one register; mirror it in the shadow copy, drop unknown indexes.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [47:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_PERSP_X || idx == REG_PERSP_Y)
            coef[idx] = val;
        else if (idx < 8)
            coef[idx] = {16'd0, val[31:0]};
    endtask

    task automatic write_all(input logic [47:0] v [8]);
        foreach (v[i])
            write_reg(CFG_INDEX_BITS'(i), v[i]);
    endtask

    // Hold the sender until every expected word is back, then let the pipe settle.
    task automatic drain();
        while (pixel_q.size() > 0 || s_tvalid || disp_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_idle(input int phase);
        unique case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
    endtask

    function automatic logic [23:0] pix(input int x, input int y);
        return {y[11:0], x[11:0]};
    endfunction

    // Mostly tame coefficients, with full-range ones mixed in.
    function automatic logic [47:0] rand_coef(input bit persp, input bit unity);
        logic [47:0] v;
        v = {$urandom(), $urandom()};
        unique case ($urandom_range(4))
            0: return v;
            1: return '0;
            2: return unity ? 48'h100_0000 + 48'($signed(v[15:0]))
                            : 48'($signed(v[19:0]));
            3: return persp ? 48'($signed(v[27:0])) : 48'($signed(v[31:0]));
            default: return persp ? 48'($signed(v[21:0])) : 48'($signed(v[25:0]));
        endcase
    endfunction

    initial
    begin
        logic [47:0] cfg [8];
        int          k;
        int          x;
        int          y;
        coef = '{48'h100_0000, 0, 0, 0, 48'h100_0000, 0, 0, 0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Identity homography: extremes of the coordinates give zero displacement.
        set_idle(0);
        pixel_q = '{pix(0, 0), pix(4095, 4095), pix(0, 4095), pix(4095, 0),
                    pix(2730, 1365), pix(1365, 2730)};
        drain();

        // Perspective row that makes W zero at column 256 and negative beyond it.
        // Also poke unknown indexes and junk upper data bits; both must drop.
        write_reg(4'd8, 48'hFFFF_FFFF_FFFF);
        write_reg(4'd15, 48'h1234_5678_9ABC);
        write_reg(REG_OFFSET_X, 48'hABCD_0001_0000);
        write_reg(REG_PERSP_X, -(48'd1 << 32));
        set_idle(1);
        pixel_q = '{pix(256, 0), pix(256, 4095), pix(512, 7), pix(4095, 4095),
                    pix(255, 0), pix(257, 1)};
        drain();

        // Huge quotient: W tiny but nonzero, numerator large.
        cfg = '{48'h7FFF_FFFF, 48'h7FFF_FFFF, 48'h7FFF_FFFF, 48'h8000_0000,
                48'h8000_0000, 48'h8000_0000, -(48'd1 << 32) + 1, 0};
        write_all(cfg);
        set_idle(2);
        pixel_q = '{pix(256, 0), pix(256, 4095), pix(0, 0), pix(4095, 4095)};
        drain();

        // Register extremes.
        cfg = '{48'h8000_0000, 48'h8000_0000, 48'h8000_0000, 48'h7FFF_FFFF,
                48'h7FFF_FFFF, 48'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000};
        write_all(cfg);
        set_idle(3);
        pixel_q = '{pix(0, 0), pix(4095, 4095), pix(1, 0), pix(0, 1), pix(4095, 1)};
        drain();

        // Random phases: fresh homography each time, pause between to drain.
        for (int ph = 0; ph < 8; ph++)
        begin
            foreach (cfg[i])
                cfg[i] = rand_coef(i >= 6, i == 0 || i == 4);
            // Now and then aim W at zero for a power-of-two column.
            k = $urandom_range(11);
            if ($urandom_range(2) == 0)
            begin
                cfg[REG_PERSP_X] = -(48'd1 << (40 - k));
                cfg[REG_PERSP_Y] = ($urandom_range(1) == 0) ? 48'd0 : cfg[REG_PERSP_Y];
            end
            write_all(cfg);
            set_idle(ph);
            for (int n = 0; n < 250; n++)
            begin
                x = $urandom_range(4095);
                y = $urandom_range(4095);
                if ($urandom_range(9) == 0)
                begin
                    x = 1 << k;
                    y = ($urandom_range(1) == 0) ? 0 : y;
                end
                pixel_q.insert(pixel_q.size(), pix(x, y));
            end
            drain();
        end

        $display("Covered %0d pixels and %0d displacement checks over 12 homographies,",
                 pixels_sent, disp_checked);
        $display("with %0d zero-denominator and %0d saturated results.",
                 zero_den_seen, clip_seen);
        if (fail_cnt == 0 && disp_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
